>>> hdl/hjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjd_pkg
// Shared types and constants for the headset jack and hook detect core.
// ----------------------------------------------------------------------------
package hjd_pkg;

  localparam int ADC_BITS = 12;

  // adc samples arrive as 12-bit fields, only the low ADC_BITS bits count
  localparam logic [11:0] ADC_MASK = 12'((64'd1 << ADC_BITS) - 64'd1);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [2:0] CFG_INSERT_ACTIVE_HIGH  = 3'd0;
  localparam logic [2:0] CFG_MIC_CHANNEL_PRESENT = 3'd1;
  localparam logic [2:0] CFG_HOOK_LOW_THRESHOLD  = 3'd2;
  localparam logic [2:0] CFG_HOOK_HIGH_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_ADC_UPPER_LIMIT     = 3'd4;

  localparam logic [11:0] RST_HOOK_LOW  = 12'd204;
  localparam logic [11:0] RST_HOOK_HIGH = 12'd410;
  localparam logic [12:0] RST_ADC_UPPER = 13'd1024;

  typedef enum logic [1:0] {
    FUNC_PIN_CHECK = 2'd0,
    FUNC_MIC_DETECT = 2'd1,
    FUNC_HOOK_POLL = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    KIND_HEADSET_IN   = 3'd0,
    KIND_HEADPHONE_IN = 3'd1,
    KIND_JACK_REMOVED = 3'd2,
    KIND_HOOK_KEY     = 3'd3,
    KIND_REQUEST_MIC  = 3'd4
  } report_kind_t;

  typedef enum logic [1:0] {
    JACK_NONE      = 2'd0,
    JACK_HEADSET   = 2'd1,
    JACK_HEADPHONE = 2'd2
  } jack_kind_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_write_t;

  // one accepted event's worth of results: one or two words
  typedef struct packed {
    logic         two;
    report_kind_t kind0;
    logic         key0;
    report_kind_t kind1;
    jack_kind_t   status;
    logic         polling;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

>>> hdl/hjd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjd_front
// Holds configuration and jack state, classifies each event and queues the
// results it causes.
// ----------------------------------------------------------------------------
module hjd_front (
  input  logic              clk,
  input  logic              rst,
  input  hjd_pkg::cfg_write_t cfg,
  input  logic              accept,
  input  logic [1:0]        func,
  input  logic              pin_level,
  input  logic [11:0]       adc_value,
  input  logic              adc_valid,
  output logic              push,
  output hjd_pkg::job_t     push_job
);

  logic        insert_active_high;
  logic        mic_channel_present;
  logic [11:0] hook_low_threshold;
  logic [11:0] hook_high_threshold;
  logic [12:0] adc_upper_limit;

  logic                jack_inserted, jack_inserted_next;
  logic                mic_found, mic_found_next;
  logic                key_held, key_held_next;
  hjd_pkg::jack_kind_t jack_kind, jack_kind_next;
  logic                hook_polling, hook_polling_next;

  logic        mapped;
  logic [11:0] val;
  logic        below_low, at_high, above_high, below_upper;
  logic        has_result;
  hjd_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_active_high  <= 1'b1;
      mic_channel_present <= 1'b1;
      hook_low_threshold  <= hjd_pkg::RST_HOOK_LOW;
      hook_high_threshold <= hjd_pkg::RST_HOOK_HIGH;
      adc_upper_limit     <= hjd_pkg::RST_ADC_UPPER;
    end else if (cfg.we) begin
      unique case (cfg.index)
        hjd_pkg::CFG_INSERT_ACTIVE_HIGH:  insert_active_high  <= cfg.data[0];
        hjd_pkg::CFG_MIC_CHANNEL_PRESENT: mic_channel_present <= cfg.data[0];
        hjd_pkg::CFG_HOOK_LOW_THRESHOLD:  hook_low_threshold  <= cfg.data[11:0];
        hjd_pkg::CFG_HOOK_HIGH_THRESHOLD: hook_high_threshold <= cfg.data[11:0];
        hjd_pkg::CFG_ADC_UPPER_LIMIT:     adc_upper_limit     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign mapped      = insert_active_high ? pin_level : ~pin_level;
  assign val         = adc_value & hjd_pkg::ADC_MASK;
  assign below_low   = val < hook_low_threshold;
  assign at_high     = val >= hook_high_threshold;
  assign above_high  = val > hook_high_threshold;
  assign below_upper = {1'b0, val} < adc_upper_limit;

  always_comb begin
    jack_inserted_next = jack_inserted;
    mic_found_next     = mic_found;
    key_held_next      = key_held;
    jack_kind_next     = jack_kind;
    hook_polling_next  = hook_polling;
    has_result         = 1'b0;
    job.two            = 1'b0;
    job.kind0          = hjd_pkg::KIND_HEADSET_IN;
    job.key0           = 1'b0;
    job.kind1          = hjd_pkg::KIND_JACK_REMOVED;
    unique case (hjd_pkg::func_t'(func))
      hjd_pkg::FUNC_PIN_CHECK: begin
        if (mapped != jack_inserted) begin
          jack_inserted_next = mapped;
          has_result         = 1'b1;
          if (mapped) begin
            if (mic_channel_present) begin
              job.kind0 = hjd_pkg::KIND_REQUEST_MIC;
            end else begin
              mic_found_next = 1'b0;
              jack_kind_next = hjd_pkg::JACK_HEADPHONE;
              job.kind0      = hjd_pkg::KIND_HEADPHONE_IN;
            end
          end else begin
            jack_kind_next    = hjd_pkg::JACK_NONE;
            hook_polling_next = 1'b0;
            mic_found_next    = 1'b0;
            if (mic_found && key_held) begin
              // release the held key before reporting removal
              key_held_next = 1'b0;
              job.two       = 1'b1;
              job.kind0     = hjd_pkg::KIND_HOOK_KEY;
            end else begin
              job.kind0 = hjd_pkg::KIND_JACK_REMOVED;
            end
          end
        end
      end
      hjd_pkg::FUNC_MIC_DETECT: begin
        has_result = 1'b1;
        if (adc_valid) begin
          if (below_low) begin
            mic_found_next = 1'b0;
          end else if (at_high) begin
            mic_found_next    = 1'b1;
            hook_polling_next = 1'b1;
          end
        end
        jack_kind_next = mic_found_next ? hjd_pkg::JACK_HEADSET : hjd_pkg::JACK_HEADPHONE;
        job.kind0 = mic_found_next ? hjd_pkg::KIND_HEADSET_IN : hjd_pkg::KIND_HEADPHONE_IN;
      end
      hjd_pkg::FUNC_HOOK_POLL: begin
        if (hook_polling) begin
          if (!adc_valid || !jack_inserted || !mapped) begin
            hook_polling_next = 1'b0;
          end else begin
            if (below_low) begin
              key_held_next = 1'b1;
            end else if (above_high && below_upper) begin
              key_held_next = 1'b0;
            end
            has_result = key_held_next != key_held;
            job.kind0  = hjd_pkg::KIND_HOOK_KEY;
            job.key0   = key_held_next;
          end
        end
      end
      default: ;
    endcase
    job.status  = jack_kind_next;
    job.polling = hook_polling_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jack_inserted <= 1'b0;
      mic_found     <= 1'b0;
      key_held      <= 1'b0;
      jack_kind     <= hjd_pkg::JACK_NONE;
      hook_polling  <= 1'b0;
    end else if (accept) begin
      jack_inserted <= jack_inserted_next;
      mic_found     <= mic_found_next;
      key_held      <= key_held_next;
      jack_kind     <= jack_kind_next;
      hook_polling  <= hook_polling_next;
    end
  end

  assign push     = accept && has_result;
  assign push_job = job;

endmodule

>>> hdl/hjd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjd_queue
// Short first-in first-out queue of result jobs between front and back.
// ----------------------------------------------------------------------------
module hjd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hjd_pkg::job_t       push_job,
  input  logic                pop,
  output hjd_pkg::job_t       head_job,
  output hjd_pkg::q_status_t  status
);

  hjd_pkg::job_t            entries [hjd_pkg::QDEPTH];
  logic [hjd_pkg::QAW-1:0]  wr_ptr;
  logic [hjd_pkg::QAW-1:0]  rd_ptr;
  logic [hjd_pkg::QAW:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head_job         = entries[rd_ptr];
  assign status.not_empty = count != '0;
  assign status.full      = count == (hjd_pkg::QAW+1)'(hjd_pkg::QDEPTH);

endmodule

>>> hdl/hjd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjd_back
// Takes jobs from the queue and sends their words one per cycle while m_tready
// is high, through a registered output stage.
// ----------------------------------------------------------------------------
module hjd_back (
  input  logic                clk,
  input  logic                rst,
  input  hjd_pkg::job_t       head_job,
  input  hjd_pkg::q_status_t  status,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);

  logic                    load;
  logic                    pending;
  hjd_pkg::job_t           held;
  hjd_pkg::report_kind_t   kind;
  logic                    key;
  hjd_pkg::jack_kind_t     jstat;
  logic                    polling;

  assign load = !m_tvalid || m_tready;
  assign pop  = load && !pending && status.not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pending  <= 1'b0;
    end else if (load) begin
      if (pending) begin
        m_tvalid <= 1'b1;
        pending  <= 1'b0;
      end else begin
        m_tvalid <= status.not_empty;
        pending  <= status.not_empty && head_job.two;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        // second word of a two-word job
        kind    <= held.kind1;
        key     <= 1'b0;
        jstat   <= held.status;
        polling <= held.polling;
        m_tlast <= 1'b1;
      end else begin
        held    <= head_job;
        kind    <= head_job.kind0;
        key     <= head_job.key0;
        jstat   <= head_job.status;
        polling <= head_job.polling;
        m_tlast <= !head_job.two;
      end
    end
  end

  assign m_tdata = {4'b0000, polling, jstat, key};
  assign m_tuser = kind;

endmodule

>>> hdl/headset_jack_and_hook_detect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// headset_jack_and_hook_detect_core
// Headset jack tracker with mic detection and hook key polling.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_*      | in  | events: tuser func, tdata pin_level/adc_value/adc_valid
//  m_*      | out | reports: tuser report_kind, tdata key/status/polling, tlast
//  cfg_*    | in  | register writes, index 0..4, no read-back
//
//  one event is accepted per cycle while s_tready is high; each yields zero, one or two words
//  words leave one per cycle while m_tready is high, via the job queue and a registered output stage
//  a four-entry job queue splits the event side from the report side
//  s_tready drops only while that queue is full
//  rst is synchronous; no clearing pass is needed
// ----------------------------------------------------------------------------
module headset_jack_and_hook_detect_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pin_level, adc_value[11:0], adc_valid
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key_pressed, jack_status[1:0], polling_active
  output logic [2:0]  m_tuser,   // report_kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  hjd_pkg::cfg_write_t cfg;
  hjd_pkg::job_t       push_job;
  hjd_pkg::job_t       head_job;
  hjd_pkg::q_status_t  q_status;
  logic                accept;
  logic                push;
  logic                pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  hjd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .func      (s_tuser),
    .pin_level (s_tdata[0]),
    .adc_value (s_tdata[12:1]),
    .adc_valid (s_tdata[13]),
    .push      (push),
    .push_job  (push_job)
  );

  hjd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  hjd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .status   (q_status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
